// ===== src/uart_fifo_xon_xoff_flow_unit_assert.svh =====
// Assertion macros shared by the serial buffer RTL.
// Uses i_clk and i_rst_n from the including module's scope; no other dependencies.
`ifndef UART_FIFO_XON_XOFF_FLOW_UNIT_ASSERT_SVH
`define UART_FIFO_XON_XOFF_FLOW_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define UFF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define UFF_IMPLY(label, ante, cons, msg) \
    `UFF_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== src/uff_pkg.sv =====
// Shared types and constants for the serial buffer with XON/XOFF flow control.
// No dependencies; every interface and module file imports this package.
package uff_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 512;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int RX_CW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int TX_CW    = $clog2(TX_DEPTH + 1);

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 8;
    localparam int RX_LVL_W = 6;
    localparam int TX_LVL_W = 10;
    localparam int LVL_W    = 6;
    localparam int FLOW_W   = 2;

    localparam int QDEPTH   = 2;
    localparam int QAW      = $clog2(QDEPTH);
    localparam int QCW      = $clog2(QDEPTH + 1);

    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic [DATA_W-1:0] XON_CHAR  = 8'h11;
    localparam logic [DATA_W-1:0] XOFF_CHAR = 8'h13;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_LINE_IN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TX_RDY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLR_RX  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLR_TX  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd7;

    // Flow control modes.
    localparam logic [FLOW_W-1:0] FLOW_NONE = 2'd0;
    localparam logic [FLOW_W-1:0] FLOW_SW   = 2'd1;
    localparam logic [FLOW_W-1:0] FLOW_HW   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FLOW_MODE  = 2'd0;
    localparam logic [1:0] REG_XOFF_LEVEL = 2'd1;
    localparam logic [1:0] REG_XON_LEVEL  = 2'd2;

    localparam logic [FLOW_W-1:0] FLOW_MODE_RST  = FLOW_NONE;
    localparam logic [LVL_W-1:0]  XOFF_LEVEL_RST = 6'd54;
    localparam logic [LVL_W-1:0]  XON_LEVEL_RST  = 6'd43;

    typedef enum logic [2:0] {
        EV_RX_IN,
        EV_READ,
        EV_WRITE,
        EV_TX_RDY,
        EV_CLR_RX,
        EV_CLR_TX,
        EV_PEEK,
        EV_STATUS
    } t_event;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_OVF   = 2'd2
    } t_status;

    typedef struct packed {
        t_event            ev;
        logic [DATA_W-1:0] data;
    } t_qitem;

    typedef struct packed {
        logic [FLOW_W-1:0] flow_mode;
        logic [LVL_W-1:0]  xoff_level;
        logic [LVL_W-1:0]  xon_level;
    } t_cfg;

endpackage

// ===== src/uff_ifs.sv =====
// Valid/ready channel interfaces for event words in and result words out.
// Depends on uff_pkg for field widths.
interface uff_item_if import uff_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] data;

    modport source (output valid, mode, data, input ready);
    modport sink   (input valid, mode, data, output ready);
endinterface

interface uff_result_if import uff_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                line_valid;
    logic [DATA_W-1:0]   line_byte;
    logic [DATA_W-1:0]   read_data;
    logic [1:0]          status;
    logic [RX_LVL_W-1:0] rx_level;
    logic [TX_LVL_W-1:0] tx_level;
    logic                xoff_active;

    modport source (output valid, line_valid, line_byte, read_data, status, rx_level,
                    tx_level, xoff_active, input ready);
    modport sink   (input valid, line_valid, line_byte, read_data, status, rx_level,
                    tx_level, xoff_active, output ready);
endinterface

// ===== src/uff_regs.sv =====
// APB-style configuration registers: flow mode and the XOFF/XON levels.
// Depends on uff_pkg.
module uff_regs import uff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [FLOW_W-1:0] r_flow_mode;
    logic [LVL_W-1:0]  r_xoff_level;
    logic [LVL_W-1:0]  r_xon_level;
    logic [1:0]        w_index;
    logic              w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[CFG_AW-1:2];
    assign w_wr    = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_mode  <= FLOW_MODE_RST;
            r_xoff_level <= XOFF_LEVEL_RST;
            r_xon_level  <= XON_LEVEL_RST;
        end else if (w_wr) begin
            case (w_index)
                REG_FLOW_MODE:  r_flow_mode  <= pwdata[FLOW_W-1:0];
                REG_XOFF_LEVEL: r_xoff_level <= pwdata[LVL_W-1:0];
                REG_XON_LEVEL:  r_xon_level  <= pwdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_FLOW_MODE:  prdata = CFG_DW'(r_flow_mode);
            REG_XOFF_LEVEL: prdata = CFG_DW'(r_xoff_level);
            REG_XON_LEVEL:  prdata = CFG_DW'(r_xon_level);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.flow_mode  = r_flow_mode;
    assign o_cfg.xoff_level = r_xoff_level;
    assign o_cfg.xon_level  = r_xon_level;

endmodule

// ===== src/uff_front.sv =====
// Front end: accepts event words, decodes the mode into an event and queues them.
// Depends on uff_pkg and uff_ifs.
module uff_front import uff_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uff_item_if.sink    i_item,
    output t_qitem      o_q_item,
    output logic        o_q_valid,
    input  logic        i_q_pop
);

    t_qitem           r_q_mem [QDEPTH];
    logic [QAW-1:0]   r_q_wptr;
    logic [QAW-1:0]   r_q_rptr;
    logic [QCW-1:0]   r_q_cnt;
    t_event           w_ev;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        case (i_item.mode)
            MODE_LINE_IN: w_ev = EV_RX_IN;
            MODE_READ:    w_ev = EV_READ;
            MODE_WRITE:   w_ev = EV_WRITE;
            MODE_TX_RDY:  w_ev = EV_TX_RDY;
            MODE_CLR_RX:  w_ev = EV_CLR_RX;
            MODE_CLR_TX:  w_ev = EV_CLR_TX;
            MODE_PEEK:    w_ev = EV_PEEK;
            MODE_STATUS:  w_ev = EV_STATUS;
            default:      w_ev = EV_STATUS;
        endcase
    end

    assign i_item.ready = (r_q_cnt != QCW'(QDEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = i_q_pop && o_q_valid;
    assign o_q_valid    = (r_q_cnt != '0);
    assign o_q_item     = r_q_mem[r_q_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wptr <= '0;
            r_q_rptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_q_mem[r_q_wptr].ev   <= w_ev;
                r_q_mem[r_q_wptr].data <= i_item.data;
                r_q_wptr <= (r_q_wptr == QAW'(QDEPTH - 1)) ? '0 : r_q_wptr + 1'b1;
            end
            if (w_pop) begin
                r_q_rptr <= (r_q_rptr == QAW'(QDEPTH - 1)) ? '0 : r_q_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_q_cnt <= r_q_cnt + 1'b1;
                2'b01:   r_q_cnt <= r_q_cnt - 1'b1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

endmodule

// ===== src/uff_back.sv =====
// Back end: owns both rings and the flow flags, executes one queued event at a time
// and holds the result word in an output register. Depends on uff_pkg and uff_ifs.
module uff_back import uff_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_qitem      i_q_item,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    uff_result_if.source o_res
);

    `include "uart_fifo_xon_xoff_flow_unit_assert.svh"

    typedef enum logic {
        ST_FETCH,
        ST_EXEC
    } t_state;

    t_state              r_state, n_state;
    t_event              r_ev;
    logic [DATA_W-1:0]   r_data;

    logic [RX_AW-1:0]    r_rx_rptr, n_rx_rptr;
    logic [RX_AW-1:0]    r_rx_wptr, n_rx_wptr;
    logic [RX_CW-1:0]    r_rx_cnt, n_rx_cnt;
    logic [TX_AW-1:0]    r_tx_rptr, n_tx_rptr;
    logic [TX_AW-1:0]    r_tx_wptr, n_tx_wptr;
    logic [TX_CW-1:0]    r_tx_cnt, n_tx_cnt;
    logic                r_xoff_wanted, n_xoff_wanted;
    logic                r_xoff_done, n_xoff_done;
    logic                r_lost, n_lost;
    logic                r_xon_pending, n_xon_pending;

    logic                r_out_valid, n_out_valid;
    logic                r_line_valid, n_line_valid;
    logic [DATA_W-1:0]   r_line_byte, n_line_byte;
    logic [DATA_W-1:0]   r_read_data, n_read_data;
    t_status             r_status, n_status;
    logic [RX_LVL_W-1:0] r_rx_level, n_rx_level;
    logic [TX_LVL_W-1:0] r_tx_level, n_tx_level;
    logic                r_xoff_active, n_xoff_active;

    logic [DATA_W-1:0]   rx_mem [RX_DEPTH];
    logic [DATA_W-1:0]   tx_mem [TX_DEPTH];
    logic [DATA_W-1:0]   r_rx_q;
    logic [DATA_W-1:0]   r_tx_q;

    logic                w_fire;
    logic                w_rx_we;
    logic                w_tx_we;
    logic [RX_CW:0]      w_rx_inc;

    assign o_q_pop  = (r_state == ST_FETCH) && i_q_valid;
    assign w_fire   = (r_state == ST_EXEC) && (!r_out_valid || o_res.ready);
    assign w_rx_inc = {1'b0, r_rx_cnt} + 1'b1;

    // Ring heads are read while the event is fetched, so the update step sees them
    // after any write made by the previous event.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH) begin
            r_rx_q <= rx_mem[r_rx_rptr];
            r_tx_q <= tx_mem[r_tx_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_we) begin
            rx_mem[r_rx_wptr] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tx_we) begin
            tx_mem[r_tx_wptr] <= r_data;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_rx_rptr     = r_rx_rptr;
        n_rx_wptr     = r_rx_wptr;
        n_rx_cnt      = r_rx_cnt;
        n_tx_rptr     = r_tx_rptr;
        n_tx_wptr     = r_tx_wptr;
        n_tx_cnt      = r_tx_cnt;
        n_xoff_wanted = r_xoff_wanted;
        n_xoff_done   = r_xoff_done;
        n_lost        = r_lost;
        n_xon_pending = r_xon_pending;
        n_line_valid  = r_line_valid;
        n_line_byte   = r_line_byte;
        n_read_data   = r_read_data;
        n_status      = r_status;
        n_rx_level    = r_rx_level;
        n_tx_level    = r_tx_level;
        n_xoff_active = r_xoff_active;
        n_out_valid   = r_out_valid && !o_res.ready;
        w_rx_we       = 1'b0;
        w_tx_we       = 1'b0;

        if (o_q_pop) begin
            n_state = ST_EXEC;
        end

        if (w_fire) begin
            n_state      = ST_FETCH;
            n_out_valid  = 1'b1;
            n_line_valid = 1'b0;
            n_line_byte  = '0;
            n_read_data  = '0;
            n_status     = STS_OK;

            case (r_ev)
                EV_RX_IN: begin
                    // A dropped byte still counts toward the XOFF request.
                    if (32'(w_rx_inc) > 32'(i_cfg.xoff_level)) begin
                        n_xoff_wanted = 1'b1;
                    end
                    if (32'(w_rx_inc) >= RX_DEPTH) begin
                        n_lost = 1'b1;
                    end else begin
                        w_rx_we   = 1'b1;
                        n_rx_wptr = (r_rx_wptr == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                       : r_rx_wptr + 1'b1;
                        n_rx_cnt  = w_rx_inc[RX_CW-1:0];
                    end
                end
                EV_READ: begin
                    if (r_rx_cnt == '0) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_read_data = r_rx_q;
                        n_rx_rptr   = (r_rx_rptr == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                         : r_rx_rptr + 1'b1;
                        n_rx_cnt    = r_rx_cnt - 1'b1;
                        if (i_cfg.flow_mode != FLOW_NONE && r_xoff_done &&
                            32'(n_rx_cnt) < 32'(i_cfg.xon_level)) begin
                            n_xoff_done   = 1'b0;
                            n_xoff_wanted = 1'b0;
                            if (i_cfg.flow_mode == FLOW_SW) begin
                                n_xon_pending = 1'b1;
                            end
                        end
                    end
                end
                EV_WRITE: begin
                    if (32'(r_tx_cnt) < TX_DEPTH) begin
                        w_tx_we   = 1'b1;
                        n_tx_wptr = (r_tx_wptr == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                       : r_tx_wptr + 1'b1;
                        n_tx_cnt  = r_tx_cnt + 1'b1;
                    end else begin
                        n_status = STS_OVF;
                    end
                end
                EV_TX_RDY: begin
                    // A pending XON goes first, then an unserved XOFF, then ring data.
                    if (r_xon_pending) begin
                        n_xon_pending = 1'b0;
                        n_line_valid  = 1'b1;
                        n_line_byte   = XON_CHAR;
                    end
                    if (r_xoff_wanted && !r_xoff_done) begin
                        if (i_cfg.flow_mode == FLOW_SW) begin
                            if (!n_line_valid) begin
                                n_xoff_done  = 1'b1;
                                n_line_valid = 1'b1;
                                n_line_byte  = XOFF_CHAR;
                            end
                        end else begin
                            n_xoff_done = 1'b1;
                        end
                    end
                    if (!n_line_valid && r_tx_cnt != '0) begin
                        n_line_valid = 1'b1;
                        n_line_byte  = r_tx_q;
                        n_tx_rptr    = (r_tx_rptr == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                          : r_tx_rptr + 1'b1;
                        n_tx_cnt     = r_tx_cnt - 1'b1;
                    end
                end
                EV_CLR_RX: begin
                    n_rx_cnt  = '0;
                    n_rx_rptr = '0;
                    n_rx_wptr = '0;
                end
                EV_CLR_TX: begin
                    n_tx_cnt  = '0;
                    n_tx_rptr = '0;
                    n_tx_wptr = '0;
                end
                EV_PEEK: begin
                    if (r_rx_cnt == '0) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_read_data = r_rx_q;
                    end
                end
                EV_STATUS: begin
                    if (r_lost) begin
                        n_lost   = 1'b0;
                        n_status = STS_OVF;
                    end
                end
                default: begin
                end
            endcase

            n_rx_level    = RX_LVL_W'(n_rx_cnt);
            n_tx_level    = TX_LVL_W'(n_tx_cnt);
            n_xoff_active = n_xoff_done && (i_cfg.flow_mode != FLOW_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_FETCH;
            r_rx_rptr     <= '0;
            r_rx_wptr     <= '0;
            r_rx_cnt      <= '0;
            r_tx_rptr     <= '0;
            r_tx_wptr     <= '0;
            r_tx_cnt      <= '0;
            r_xoff_wanted <= 1'b0;
            r_xoff_done   <= 1'b0;
            r_lost        <= 1'b0;
            r_xon_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_rx_rptr     <= n_rx_rptr;
            r_rx_wptr     <= n_rx_wptr;
            r_rx_cnt      <= n_rx_cnt;
            r_tx_rptr     <= n_tx_rptr;
            r_tx_wptr     <= n_tx_wptr;
            r_tx_cnt      <= n_tx_cnt;
            r_xoff_wanted <= n_xoff_wanted;
            r_xoff_done   <= n_xoff_done;
            r_lost        <= n_lost;
            r_xon_pending <= n_xon_pending;
            r_out_valid   <= n_out_valid;
            r_line_valid  <= n_line_valid;
            r_line_byte   <= n_line_byte;
            r_read_data   <= n_read_data;
            r_status      <= n_status;
            r_rx_level    <= n_rx_level;
            r_tx_level    <= n_tx_level;
            r_xoff_active <= n_xoff_active;
            if (o_q_pop) begin
                r_ev   <= i_q_item.ev;
                r_data <= i_q_item.data;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.line_valid  = r_line_valid;
    assign o_res.line_byte   = r_line_byte;
    assign o_res.read_data   = r_read_data;
    assign o_res.status      = r_status;
    assign o_res.rx_level    = r_rx_level;
    assign o_res.tx_level    = r_tx_level;
    assign o_res.xoff_active = r_xoff_active;

    `UFF_ASSERT(a_rx_cnt_max, 32'(r_rx_cnt) < RX_DEPTH, "receive count beyond ring capacity")
    `UFF_ASSERT(a_tx_cnt_max, 32'(r_tx_cnt) <= TX_DEPTH, "transmit count beyond ring capacity")
    `UFF_IMPLY(a_xon_sw_only, $rose(r_xon_pending), i_cfg.flow_mode == FLOW_SW, "stray XON")
    `UFF_IMPLY(a_res_from_exec, $rose(r_out_valid), $past(r_state) == ST_EXEC, "stray result")

endmodule

// ===== src/uart_fifo_xon_xoff_flow_unit.sv =====
// Top level of the buffered serial link with XON/XOFF flow control.
// Depends on uff_pkg, uff_ifs, uff_regs, uff_front and uff_back.
//
//   Channel   Direction  Handshake           Word
//   i_item    in         valid/ready         mode, data
//   o_result  out        valid/ready         line_valid .. xoff_active
//   config    in         APB psel/penable    flow_mode, xoff_level, xon_level
//
// Each event passes through two steps in the back end: a fetch step that reads both ring
// heads from their registered-read memories, and an update step that updates the rings and
// flags and loads the result register; the next event is fetched only after that update.
// The front queue holds two events, so input stays open while the back end works until it is full.
// The back end waits in its update step while the result register is full and not taken.
// Reset is synchronous; no clearing pass is needed since ring contents are only read
// after being written.
module uart_fifo_xon_xoff_flow_unit import uff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uff_item_if.sink          i_item,
    uff_result_if.source      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg   w_cfg;
    t_qitem w_q_item;
    logic   w_q_valid;
    logic   w_q_pop;

    uff_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    uff_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_item  (w_q_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop)
    );

    uff_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_item  (w_q_item),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .o_res     (o_result)
    );

endmodule
